@@ design/rcfds_pkg.sv @@
package rcfds_pkg;

  localparam int PayloadLen = 5;

  localparam logic [7:0] START_BYTE = 8'h66;
  localparam logic [7:0] END_BYTE   = 8'h99;
  localparam logic [7:0] CENTER     = 8'h80;

  localparam logic signed [28:0] CENTER_BASE_Q16 = 29'sd98304000;
  localparam logic [27:0]        THRUST_BASE_Q16 = 28'd65536000;
  localparam logic signed [19:0] ROLL_GAIN_Q16   = 20'sd426667;
  localparam logic signed [19:0] YAW_GAIN_Q16    = 20'sd258271;
  localparam logic [17:0]        THRUST_GAIN_Q16 = 18'd256004;

  typedef struct packed {
    logic                             valid;
    logic [PayloadLen-1:0][7:0]       payload;
  } frame_t;

  typedef struct packed {
    logic [7:0]  command_bits;
    logic [10:0] thrust_width;
    logic [10:0] yaw_width;
    logic [11:0] pitch_width;
    logic [11:0] roll_width;
  } result_t;

endpackage

@@ design/rcfds_parser.sv @@
module rcfds_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output rcfds_pkg::frame_t    frame
);

  typedef enum logic [1:0] {PH_WAIT, PH_DATA, PH_CHK, PH_END} phase_t;

  phase_t     phase;
  logic [2:0] payload_count;
  logic [rcfds_pkg::PayloadLen-1:0][7:0] payload_store;
  logic [7:0] checksum;

  always_comb begin
    checksum = '0;
    for (int i = 0; i < rcfds_pkg::PayloadLen; i++) begin
      checksum = checksum ^ payload_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      payload_count <= '0;
    end else if (in_valid) begin
      case (phase)
        PH_WAIT: begin
          if (in_byte == rcfds_pkg::START_BYTE) begin
            payload_count <= '0;
            phase         <= PH_DATA;
          end
        end
        PH_DATA: begin
          payload_count <= payload_count + 3'd1;
          if (payload_count == 3'(rcfds_pkg::PayloadLen - 1)) begin
            phase <= PH_CHK;
          end
        end
        PH_CHK: begin
          phase <= (checksum == in_byte) ? PH_END : PH_WAIT;
        end
        default: begin
          phase <= PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && phase == PH_DATA) begin
      for (int i = 0; i < rcfds_pkg::PayloadLen; i++) begin
        if (payload_count == 3'(i)) begin
          payload_store[i] <= in_byte;
        end
      end
    end
  end

  assign frame.valid   = in_valid && phase == PH_END && in_byte == rcfds_pkg::END_BYTE;
  assign frame.payload = payload_store;

endmodule

@@ design/rcfds_scaler.sv @@
module rcfds_scaler (
  input  rcfds_pkg::frame_t   frame,
  output rcfds_pkg::result_t  result
);

  logic signed [8:0]  roll_offset;
  logic signed [8:0]  pitch_offset;
  logic signed [8:0]  yaw_offset;
  logic signed [28:0] roll_acc;
  logic signed [28:0] pitch_acc;
  logic signed [28:0] yaw_acc;
  logic [27:0]        thrust_acc;

  assign roll_offset  = $signed({1'b0, frame.payload[0]}) - $signed({1'b0, rcfds_pkg::CENTER});
  assign pitch_offset = $signed({1'b0, frame.payload[1]}) - $signed({1'b0, rcfds_pkg::CENTER});
  assign yaw_offset   = $signed({1'b0, frame.payload[3]}) - $signed({1'b0, rcfds_pkg::CENTER});

  assign roll_acc  = rcfds_pkg::CENTER_BASE_Q16
                   + 29'(roll_offset) * 29'(rcfds_pkg::ROLL_GAIN_Q16);
  assign pitch_acc = rcfds_pkg::CENTER_BASE_Q16
                   + 29'(pitch_offset) * 29'(rcfds_pkg::ROLL_GAIN_Q16);
  assign yaw_acc   = rcfds_pkg::CENTER_BASE_Q16
                   + 29'(yaw_offset) * 29'(rcfds_pkg::YAW_GAIN_Q16);
  assign thrust_acc = rcfds_pkg::THRUST_BASE_Q16
                    + 28'(frame.payload[2]) * 28'(rcfds_pkg::THRUST_GAIN_Q16);

  assign result.roll_width   = roll_acc[27:16];
  assign result.pitch_width  = pitch_acc[27:16];
  assign result.yaw_width    = yaw_acc[26:16];
  assign result.thrust_width = thrust_acc[26:16];
  assign result.command_bits = frame.payload[4];

endmodule

@@ design/rc_frame_deframer_scaler.sv @@
// Control-link frame parser with servo pulse-width scaling. Received bytes
// enter on the slave stream, one per cycle at full rate while tready is high; a frame
// is a start byte 0x66, five payload bytes, an XOR checksum byte and an end
// byte 0x99, and each valid frame yields one master transaction with the roll,
// pitch, yaw and thrust widths in microseconds and the raw command byte. A
// byte is registered, parsed and scaled in the following cycle, and the result
// is registered. A two-entry output buffer absorbs stalls; the input deasserts
// tready only while that buffer is full or about to be.
module rc_frame_deframer_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // roll_width[11:0], pitch_width[23:12], yaw_width[34:24],
                                 // thrust_width[45:35], command_bits[53:46], zero[55:54]
);

  logic                in_valid;
  logic [7:0]          in_byte;
  rcfds_pkg::frame_t   frame;
  rcfds_pkg::result_t  result;
  logic                out_valid;
  rcfds_pkg::result_t  out_data;
  logic                skid_valid;
  rcfds_pkg::result_t  skid_data;
  logic                pop;

  assign pop      = out_valid && m_tready;
  assign s_tready = !skid_valid && !(out_valid && in_valid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  rcfds_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .frame    (frame)
  );

  rcfds_scaler u_scaler (
    .frame  (frame),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= frame.valid;
        out_data  <= result;
      end
    end else if (frame.valid) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_data};

endmodule

@@ sim/tb.sv @@
typedef enum logic [1:0] {
  WAIT_START,
  COLLECT,
  WAIT_CHECK,
  WAIT_END
} link_phase_t;

class rc_frame_scoreboard;
  link_phase_t          phase;
  int unsigned          count;
  logic [7:0]           store [rcfds_pkg::PayloadLen];
  rcfds_pkg::result_t   frames_q [$];
  int unsigned          mismatches;

  function new();
    phase = WAIT_START;
    count = 0;
    mismatches = 0;
  endfunction

  function logic [11:0] centred_width(logic [7:0] b, int gain);
    int acc;
    acc = 1500 * 65536 + (int'(b) - 128) * gain;
    return acc[27:16];
  endfunction

  function void report(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s expected %0d actual %0d", $realtime, what, want, got);
    end
  endfunction

  // Called for every accepted input transaction.
  function void take_byte(logic [7:0] b);
    logic [7:0]         sum;
    int                 thr;
    rcfds_pkg::result_t r;
    case (phase)
      WAIT_START: begin
        if (b == rcfds_pkg::START_BYTE) begin
          count = 0;
          phase = COLLECT;
        end
      end
      COLLECT: begin
        store[count] = b;
        count++;
        if (count == rcfds_pkg::PayloadLen) phase = WAIT_CHECK;
      end
      WAIT_CHECK: begin
        sum = store[0] ^ store[1] ^ store[2] ^ store[3] ^ store[4];
        phase = (sum == b) ? WAIT_END : WAIT_START;
      end
      default: begin
        phase = WAIT_START;
        if (b == rcfds_pkg::END_BYTE) begin
          r.roll_width   = centred_width(store[0], int'(rcfds_pkg::ROLL_GAIN_Q16));
          r.pitch_width  = centred_width(store[1], int'(rcfds_pkg::ROLL_GAIN_Q16));
          r.yaw_width    = 11'(centred_width(store[3], int'(rcfds_pkg::YAW_GAIN_Q16)));
          thr            = 1000 * 65536
                         + int'(store[2]) * int'(rcfds_pkg::THRUST_GAIN_Q16);
          r.thrust_width = thr[26:16];
          r.command_bits = store[4];
          frames_q.push_back(r);
        end
      end
    endcase
  endfunction

  // Called for every accepted output transaction.
  function void check_frame(logic [55:0] data);
    rcfds_pkg::result_t got;
    rcfds_pkg::result_t want;
    got = data[53:0];
    if (frames_q.size() == 0) begin
      report("unexpected result, data", 0, data);
      return;
    end
    want = frames_q.pop_front();
    if (got.roll_width != want.roll_width)
      report("roll_width", want.roll_width, got.roll_width);
    if (got.pitch_width != want.pitch_width)
      report("pitch_width", want.pitch_width, got.pitch_width);
    if (got.yaw_width != want.yaw_width)
      report("yaw_width", want.yaw_width, got.yaw_width);
    if (got.thrust_width != want.thrust_width)
      report("thrust_width", want.thrust_width, got.thrust_width);
    if (got.command_bits != want.command_bits)
      report("command_bits", want.command_bits, got.command_bits);
    if (data[55:54] != 2'b00)
      report("padding", 0, data[55:54]);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 50;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  bit          hold_req = 1'b0;

  rc_frame_scoreboard sb = new();

  rc_frame_deframer_scaler i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_frame(m_tdata);
  end

  // The long hold-off lets the output buffer fill so that the input stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [7:0] xor_of(logic [rcfds_pkg::PayloadLen-1:0][7:0] p);
    return p[0] ^ p[1] ^ p[2] ^ p[3] ^ p[4];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return rcfds_pkg::CENTER;
      3:       return rcfds_pkg::START_BYTE;
      4:       return rcfds_pkg::END_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [rcfds_pkg::PayloadLen-1:0][7:0] p,
                            input logic [7:0] chk, input logic [7:0] tail);
    send_byte(rcfds_pkg::START_BYTE);
    for (int i = 0; i < rcfds_pkg::PayloadLen; i++) send_byte(p[i]);
    send_byte(chk);
    send_byte(tail);
  endtask

  task automatic random_frame();
    logic [rcfds_pkg::PayloadLen-1:0][7:0] p;
    logic [7:0]                            tail;
    int unsigned                           r;
    int unsigned                           n;
    for (int i = 0; i < rcfds_pkg::PayloadLen; i++) p[i] = pick_byte();
    r = $urandom_range(99);
    if (r < 70) begin
      send_frame(p, xor_of(p), rcfds_pkg::END_BYTE);
    end else if (r < 80) begin
      send_frame(p, xor_of(p) ^ (8'd1 << $urandom_range(7)), rcfds_pkg::END_BYTE);
    end else if (r < 88) begin
      if ($urandom_range(1)) begin
        tail = rcfds_pkg::START_BYTE;
      end else begin
        do tail = 8'($urandom_range(255)); while (tail == rcfds_pkg::END_BYTE);
      end
      send_frame(p, xor_of(p), tail);
    end else if (r < 94) begin
      send_byte(rcfds_pkg::START_BYTE);
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(p[i]);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [rcfds_pkg::PayloadLen-1:0][7:0] p;
    int unsigned                           target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    p = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    send_frame(p, xor_of(p), rcfds_pkg::END_BYTE);
    p = ~p;
    send_frame(p, xor_of(p), rcfds_pkg::END_BYTE);
    p = {8'h9A, 8'h78, 8'h56, 8'h34, 8'h12};
    send_frame(p, xor_of(p) ^ 8'h01, rcfds_pkg::END_BYTE);
    p = {rcfds_pkg::CENTER, rcfds_pkg::CENTER, rcfds_pkg::CENTER, rcfds_pkg::CENTER,
         rcfds_pkg::CENTER};
    send_frame(p, xor_of(p), rcfds_pkg::START_BYTE);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) random_frame();
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (sb.frames_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/rcfds_pkg.sv
design/rcfds_parser.sv
design/rcfds_scaler.sv
design/rc_frame_deframer_scaler.sv
sim/tb.sv
